// File: sv/scpc_pkg.sv
// ============================================================================
// scpc_pkg - shared types and constants
// Widths, register indexes, reset values and control structs used across the
// strain-compliant position controller.
// ============================================================================
`default_nettype none

package scpc_pkg;

    // motors
    localparam int MOTOR_COUNT   = 4;
    localparam int MOTOR_W       = 2;
    localparam int STRAIN_OFFSET = 126;

    // field widths
    localparam int POS_W    = 16;
    localparam int STRAIN_W = 8;
    localparam int TIME_W   = 20;
    localparam int DZ_W     = 16;
    localparam int CG_W     = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 15;
    localparam int CMD_W    = 16;
    localparam int FILT_W   = 18;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // internal datapath widths
    localparam int SX_W     = STRAIN_W + 1;           // strain less offset
    localparam int P1_W     = SX_W + TIME_W + 1;      // strain * dt
    localparam int P2_W     = FILT_W + TIME_W + 1;    // prev * a
    localparam int NUM_W    = P2_W + 1;               // filter numerator
    localparam int DEN_W    = TIME_W + 1;             // a + dt
    localparam int QUO_W    = FILT_W;                 // filter quotient magnitude
    localparam int DVD_W    = QUO_W + DEN_W;          // divider dividend
    localparam int CNT_W    = 5;
    localparam int DX_W     = FILT_W + 1;
    localparam int CGH_W    = CG_W + 1 + FILT_W;      // gain * held strain
    localparam int ERR_W    = CGH_W + 1;
    localparam int EMAG_W   = ERR_W - 2;
    localparam int EHALF_W  = EMAG_W / 2;
    localparam int PP_W     = EHALF_W + GAIN_W;
    localparam int RSUM_W   = EMAG_W + GAIN_W + 1;
    localparam int ROUND_SH = 32;
    localparam int RMAG_W   = RSUM_W - ROUND_SH;
    localparam int POS_SH   = 12;
    localparam int STRAIN_SH = 8;

    // register reset values
    localparam logic [TIME_W-1:0]  FILTER_TIME_RST = TIME_W'(300000);
    localparam logic [DZ_W-1:0]    DEADZONE_RST    = DZ_W'(77);
    localparam logic [CG_W-1:0]    COMPLIANCE_RST  = CG_W'(1638);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_TIME  = 3'd0,
        CFG_DEADZONE     = 3'd1,
        CFG_COMPLIANCE   = 3'd2,
        CFG_FINGER_GAIN  = 3'd3,
        CFG_SPREAD_GAIN  = 3'd4,
        CFG_FINGER_LIMIT = 3'd5,
        CFG_SPREAD_LIMIT = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  filter_time_us;
        logic [DZ_W-1:0]    strain_deadzone;
        logic [CG_W-1:0]    compliance_gain;
        logic [GAIN_W-1:0]  finger_gain;
        logic [GAIN_W-1:0]  spread_gain;
        logic [LIMIT_W-1:0] finger_limit;
        logic [LIMIT_W-1:0] spread_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_DEAD,
        ST_EMUL,
        ST_ESUM,
        ST_GMUL,
        ST_GSUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic sum;
        logic div_start;
        logic fix;
        logic dead;
        logic emul;
        logic esum;
        logic gmul;
        logic gsum;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/scpc_div.sv
// ============================================================================
// scpc_div - restoring divider
// Unsigned division, one quotient bit per cycle. The upper dividend bits must
// already be below the divisor, so QUO_W steps give the whole quotient.
// ============================================================================
`default_nettype none

module scpc_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [scpc_pkg::DVD_W-1:0]   dividend,
    input  wire logic [scpc_pkg::DEN_W-1:0]   divisor,
    output logic      [scpc_pkg::QUO_W-1:0]   quotient,
    output logic                              busy
);

    logic [scpc_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [scpc_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [scpc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [scpc_pkg::DEN_W:0]   trial;
    logic [scpc_pkg::DEN_W:0]   diff;
    logic                       ge;

    // one trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[scpc_pkg::QUO_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = ~diff[scpc_pkg::DEN_W];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend[scpc_pkg::DVD_W-1:scpc_pkg::QUO_W];
            quo_next  = dividend[scpc_pkg::QUO_W-1:0];
            cnt_next  = scpc_pkg::CNT_W'(scpc_pkg::QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[scpc_pkg::DEN_W-1:0] : trial[scpc_pkg::DEN_W-1:0];
            quo_next  = {quo_reg[scpc_pkg::QUO_W-2:0], ge};
            cnt_next  = cnt_reg - scpc_pkg::CNT_W'(1);
            busy_next = (cnt_reg != scpc_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

`default_nettype wire

// File: sv/scpc_dp.sv
// ============================================================================
// scpc_dp - controller datapath
// Strain filter with per-motor state, deadzone, compliance error and the
// rounded, clamped proportional command. Steps advance on controller commands.
// ============================================================================
`default_nettype none

module scpc_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire scpc_pkg::cmd_t                       cmd,
    output scpc_pkg::sts_t                            sts,
    input  wire scpc_pkg::cfg_t                       cfg,
    input  wire logic        [scpc_pkg::MOTOR_W-1:0]  motor,
    input  wire logic signed [scpc_pkg::POS_W-1:0]    target_position,
    input  wire logic signed [scpc_pkg::POS_W-1:0]    measured_position,
    input  wire logic        [scpc_pkg::STRAIN_W-1:0] raw_strain,
    input  wire logic        [scpc_pkg::TIME_W-1:0]   elapsed_us,
    output logic signed      [scpc_pkg::CMD_W-1:0]    velocity_command,
    output logic signed      [scpc_pkg::FILT_W-1:0]   filtered_strain,
    output logic                                      saturated
);

    // per-motor filter state
    logic signed [scpc_pkg::FILT_W-1:0] filt_reg [scpc_pkg::MOTOR_COUNT];

    // request capture
    logic [scpc_pkg::MOTOR_W-1:0]        motor_reg;
    logic                                motor_ok_reg;
    logic                                spread_reg;
    logic signed [scpc_pkg::SX_W-1:0]    strain_reg;
    logic [scpc_pkg::TIME_W-1:0]         dt_reg;
    logic signed [scpc_pkg::POS_W:0]     diff_reg;
    logic signed [scpc_pkg::FILT_W-1:0]  prev_reg;

    logic                                motor_ok_in;
    logic                                spread_in;
    logic signed [scpc_pkg::SX_W-1:0]    strain_in;
    logic signed [scpc_pkg::POS_W:0]     diff_in;
    logic signed [scpc_pkg::FILT_W-1:0]  prev_in;

    // filter
    logic signed [scpc_pkg::P1_W-1:0]    p1_reg;
    logic signed [scpc_pkg::P2_W-1:0]    p2_reg;
    logic [scpc_pkg::DEN_W-1:0]          den_reg;
    logic signed [scpc_pkg::NUM_W-1:0]   num_reg;
    logic [scpc_pkg::NUM_W-1:0]          half;
    logic [scpc_pkg::NUM_W-1:0]          dividend;
    logic [scpc_pkg::QUO_W-1:0]          quotient;
    logic                                div_busy;
    logic [scpc_pkg::QUO_W:0]            qs;
    logic [scpc_pkg::QUO_W:0]            yq;
    logic signed [scpc_pkg::FILT_W-1:0]  y_next;
    logic signed [scpc_pkg::FILT_W-1:0]  y_reg;

    // deadzone and error
    logic signed [scpc_pkg::DX_W-1:0]    dx;
    logic signed [scpc_pkg::DX_W-1:0]    dzs;
    logic                                hold;
    logic signed [scpc_pkg::FILT_W-1:0]  held_reg;
    logic signed [scpc_pkg::CGH_W-1:0]   cgh_reg;
    logic signed [scpc_pkg::ERR_W-1:0]   epos;
    logic signed [scpc_pkg::ERR_W-1:0]   ecgh;
    logic [scpc_pkg::ERR_W-1:0]          errp;
    logic [scpc_pkg::ERR_W-1:0]          errn;
    logic                                eneg_reg;
    logic [scpc_pkg::EMAG_W-1:0]         emag_reg;

    // gain, rounding, clamp
    logic [scpc_pkg::GAIN_W-1:0]         gain;
    logic [scpc_pkg::PP_W-1:0]           pl_reg;
    logic [scpc_pkg::PP_W-1:0]           ph_reg;
    logic [scpc_pkg::RSUM_W-1:0]         rsum;
    logic [scpc_pkg::RMAG_W-1:0]         rmag_reg;
    logic [scpc_pkg::LIMIT_W-1:0]        limit;
    logic                                sat;
    logic [scpc_pkg::CMD_W-1:0]          mag_l;
    logic [scpc_pkg::CMD_W-1:0]          mag_r;
    logic [scpc_pkg::CMD_W-1:0]          cmd_val;

    logic signed [scpc_pkg::CMD_W-1:0]   vel_reg;
    logic signed [scpc_pkg::FILT_W-1:0]  fout_reg;
    logic                                sat_reg;

    // ---------------- request capture ----------------
    always_comb
    begin
        motor_ok_in = int'(motor) < scpc_pkg::MOTOR_COUNT;
        spread_in   = int'(motor) == (scpc_pkg::MOTOR_COUNT - 1);
        strain_in   = $signed({1'b0, raw_strain} - scpc_pkg::SX_W'(scpc_pkg::STRAIN_OFFSET));
        diff_in     = $signed({target_position[scpc_pkg::POS_W-1], target_position})
                    - $signed({measured_position[scpc_pkg::POS_W-1], measured_position});
        prev_in     = motor_ok_in ? filt_reg[motor] : '0;
    end

    // ---------------- filter ----------------
    always_comb
    begin
        half     = scpc_pkg::NUM_W'(den_reg >> 1);
        // magnitude of the numerator plus half the denominator
        dividend = num_reg[scpc_pkg::NUM_W-1] ? (half - $unsigned(num_reg))
                                              : ($unsigned(num_reg) + half);
        qs       = {1'b0, quotient};
        yq       = num_reg[scpc_pkg::NUM_W-1] ? (~qs + 1'b1) : qs;
        y_next   = (den_reg == '0) ? prev_reg : $signed(yq[scpc_pkg::FILT_W-1:0]);
    end

    scpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend[scpc_pkg::DVD_W-1:0]),
        .divisor  (den_reg),
        .quotient (quotient),
        .busy     (div_busy)
    );

    assign sts.div_busy = div_busy;

    // ---------------- deadzone and error ----------------
    always_comb
    begin
        dx   = $signed({y_reg[scpc_pkg::FILT_W-1], y_reg})
             - $signed({prev_reg[scpc_pkg::FILT_W-1], prev_reg});
        dzs  = $signed({{(scpc_pkg::DX_W - scpc_pkg::DZ_W){1'b0}}, cfg.strain_deadzone});
        hold = (dx < dzs) && (dx > -dzs);

        epos = scpc_pkg::ERR_W'(diff_reg) <<< scpc_pkg::POS_SH;
        ecgh = scpc_pkg::ERR_W'(cgh_reg);
        errp = $unsigned(epos - ecgh);
        errn = $unsigned(ecgh - epos);
    end

    // ---------------- gain, rounding, clamp ----------------
    always_comb
    begin
        gain  = spread_reg ? cfg.spread_gain : cfg.finger_gain;
        limit = spread_reg ? cfg.spread_limit : cfg.finger_limit;
        rsum  = {1'b0, ph_reg, {scpc_pkg::EHALF_W{1'b0}}}
              + scpc_pkg::RSUM_W'(pl_reg)
              + (scpc_pkg::RSUM_W'(1) << (scpc_pkg::ROUND_SH - 1));
        sat   = rmag_reg > scpc_pkg::RMAG_W'(limit);
        mag_l = {1'b0, limit};
        mag_r = rmag_reg[scpc_pkg::CMD_W-1:0];
        if (sat)
            cmd_val = eneg_reg ? (~mag_l + 1'b1) : mag_l;
        else
            cmd_val = eneg_reg ? (~mag_r + 1'b1) : mag_r;
    end

    // filter state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scpc_pkg::MOTOR_COUNT; i++)
            begin
                filt_reg[i] <= '0;
            end
        end
        else if (cmd.fix && motor_ok_reg)
        begin
            filt_reg[motor_reg] <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            motor_reg    <= motor;
            motor_ok_reg <= motor_ok_in;
            spread_reg   <= spread_in;
            strain_reg   <= strain_in;
            dt_reg       <= elapsed_us;
            diff_reg     <= diff_in;
            prev_reg     <= prev_in;
        end
        if (cmd.mul)
        begin
            p1_reg  <= strain_reg * $signed({1'b0, dt_reg});
            p2_reg  <= prev_reg * $signed({1'b0, cfg.filter_time_us});
            den_reg <= {1'b0, cfg.filter_time_us} + {1'b0, dt_reg};
        end
        if (cmd.sum)
        begin
            num_reg <= (scpc_pkg::NUM_W'(p1_reg) <<< scpc_pkg::STRAIN_SH)
                     + scpc_pkg::NUM_W'(p2_reg);
        end
        if (cmd.fix)
        begin
            y_reg <= y_next;
        end
        if (cmd.dead)
        begin
            held_reg <= hold ? prev_reg : y_reg;
        end
        if (cmd.emul)
        begin
            cgh_reg <= $signed({1'b0, cfg.compliance_gain}) * held_reg;
        end
        if (cmd.esum)
        begin
            eneg_reg <= errp[scpc_pkg::ERR_W-1];
            emag_reg <= errp[scpc_pkg::ERR_W-1] ? errn[scpc_pkg::EMAG_W-1:0]
                                                : errp[scpc_pkg::EMAG_W-1:0];
        end
        if (cmd.gmul)
        begin
            pl_reg <= emag_reg[scpc_pkg::EHALF_W-1:0] * gain;
            ph_reg <= emag_reg[scpc_pkg::EMAG_W-1:scpc_pkg::EHALF_W] * gain;
        end
        if (cmd.gsum)
        begin
            rmag_reg <= rsum[scpc_pkg::RSUM_W-1:scpc_pkg::ROUND_SH];
        end
        if (cmd.load_out)
        begin
            vel_reg  <= $signed(cmd_val);
            fout_reg <= y_reg;
            sat_reg  <= sat;
        end
    end

    assign velocity_command = vel_reg;
    assign filtered_strain  = fout_reg;
    assign saturated        = sat_reg;

endmodule

`default_nettype wire

// File: sv/scpc_ctrl.sv
// ============================================================================
// scpc_ctrl - sequencing state machine
// Steps one request through the datapath and owns the output valid flag.
// ============================================================================
`default_nettype none

module scpc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output scpc_pkg::cmd_t       cmd,
    input  wire scpc_pkg::sts_t  sts
);

    scpc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = ~out_valid_reg | out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scpc_pkg::ST_IDLE: if (in_valid) state_next = scpc_pkg::ST_MUL;
            scpc_pkg::ST_MUL:  state_next = scpc_pkg::ST_SUM;
            scpc_pkg::ST_SUM:  state_next = scpc_pkg::ST_ABS;
            scpc_pkg::ST_ABS:  state_next = scpc_pkg::ST_DIV;
            scpc_pkg::ST_DIV:  if (!sts.div_busy) state_next = scpc_pkg::ST_FIX;
            scpc_pkg::ST_FIX:  state_next = scpc_pkg::ST_DEAD;
            scpc_pkg::ST_DEAD: state_next = scpc_pkg::ST_EMUL;
            scpc_pkg::ST_EMUL: state_next = scpc_pkg::ST_ESUM;
            scpc_pkg::ST_ESUM: state_next = scpc_pkg::ST_GMUL;
            scpc_pkg::ST_GMUL: state_next = scpc_pkg::ST_GSUM;
            scpc_pkg::ST_GSUM: state_next = scpc_pkg::ST_OUT;
            scpc_pkg::ST_OUT:  if (out_free) state_next = scpc_pkg::ST_IDLE;
            default:           state_next = scpc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            scpc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            scpc_pkg::ST_MUL:  cmd.mul       = 1'b1;
            scpc_pkg::ST_SUM:  cmd.sum       = 1'b1;
            scpc_pkg::ST_ABS:  cmd.div_start = 1'b1;
            scpc_pkg::ST_DIV:  cmd.fix       = ~sts.div_busy;
            scpc_pkg::ST_FIX:  cmd.dead      = 1'b1;
            scpc_pkg::ST_DEAD: cmd.emul      = 1'b1;
            scpc_pkg::ST_EMUL: cmd.esum      = 1'b1;
            scpc_pkg::ST_ESUM: cmd.gmul      = 1'b1;
            scpc_pkg::ST_GMUL: cmd.gsum      = 1'b1;
            scpc_pkg::ST_GSUM: cmd.load_out  = 1'b0;
            scpc_pkg::ST_OUT:  cmd.load_out  = out_free;
            default:           cmd           = '0;
        endcase
        out_valid_next = cmd.load_out | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scpc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/strain_compliant_position_control.sv
// ============================================================================
// strain_compliant_position_control - top level
// Per-motor proportional position control with strain-gauge compliance.
// ----------------------------------------------------------------------------
// Usage:
//  - Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
//    write only while no request is in flight. Reset restores the defaults.
//  - Input channel (in_valid/in_ready): one request per control tick carries
//    motor, target and measured position, raw strain and elapsed time.
//  - Output channel (out_valid/out_ready): one result per request, held in an
//    output register until taken.
//  - Sequencing: a request is worked through the sequencer steps in turn, and
//    a new request is taken only once the last one has left them. The strain
//    filter step uses a restoring divider (one quotient bit per cycle).
//  - The output register separates the two sides: the next request is taken
//    and worked on while a result waits. If the receiver still stalls when
//    the next result is ready, the sequencer holds in its last step.
//  - Reset (rst_n, asynchronous, active low) clears the filter state of every
//    motor, empties the output register and loads the register defaults.
// ============================================================================
`default_nettype none

module strain_compliant_position_control (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_we,
    input  wire logic        [scpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [scpc_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic        [scpc_pkg::MOTOR_W-1:0]    motor,
    input  wire logic signed [scpc_pkg::POS_W-1:0]      target_position,
    input  wire logic signed [scpc_pkg::POS_W-1:0]      measured_position,
    input  wire logic        [scpc_pkg::STRAIN_W-1:0]   raw_strain,
    input  wire logic        [scpc_pkg::TIME_W-1:0]     elapsed_us,
    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed      [scpc_pkg::CMD_W-1:0]      velocity_command,
    output logic signed      [scpc_pkg::FILT_W-1:0]     filtered_strain,
    output logic                                        saturated
);

    scpc_pkg::cfg_t cfg_reg, cfg_next;
    scpc_pkg::cmd_t cmd;
    scpc_pkg::sts_t sts;

    // register file: unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (scpc_pkg::cfg_idx_t'(cfg_index))
                scpc_pkg::CFG_FILTER_TIME:
                    cfg_next.filter_time_us  = cfg_data[scpc_pkg::TIME_W-1:0];
                scpc_pkg::CFG_DEADZONE:
                    cfg_next.strain_deadzone = cfg_data[scpc_pkg::DZ_W-1:0];
                scpc_pkg::CFG_COMPLIANCE:
                    cfg_next.compliance_gain = cfg_data[scpc_pkg::CG_W-1:0];
                scpc_pkg::CFG_FINGER_GAIN:
                    cfg_next.finger_gain     = cfg_data[scpc_pkg::GAIN_W-1:0];
                scpc_pkg::CFG_SPREAD_GAIN:
                    cfg_next.spread_gain     = cfg_data[scpc_pkg::GAIN_W-1:0];
                scpc_pkg::CFG_FINGER_LIMIT:
                    cfg_next.finger_limit    = cfg_data[scpc_pkg::LIMIT_W-1:0];
                scpc_pkg::CFG_SPREAD_LIMIT:
                    cfg_next.spread_limit    = cfg_data[scpc_pkg::LIMIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_time_us  <= scpc_pkg::FILTER_TIME_RST;
            cfg_reg.strain_deadzone <= scpc_pkg::DEADZONE_RST;
            cfg_reg.compliance_gain <= scpc_pkg::COMPLIANCE_RST;
            cfg_reg.finger_gain     <= '0;
            cfg_reg.spread_gain     <= '0;
            cfg_reg.finger_limit    <= '0;
            cfg_reg.spread_limit    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer
    scpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic, filter state and output register
    scpc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg               (cfg_reg),
        .motor             (motor),
        .target_position   (target_position),
        .measured_position (measured_position),
        .raw_strain        (raw_strain),
        .elapsed_us        (elapsed_us),
        .velocity_command  (velocity_command),
        .filtered_strain   (filtered_strain),
        .saturated         (saturated)
    );

endmodule

`default_nettype wire
